### design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key/value cache
// Holds the sequencer states, the recency command struct and the defaults
// for the capacity register and the entry count.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Default number of entries in the store
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // Field widths fixed by the interface
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 5;

  // Capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  // Command to the recency cells
  typedef struct packed {
    logic touch;  // age younger entries, make slot most recent
    logic fill;   // same, and also mark slot valid and bump the count
  } rec_cmd_t;

endpackage

### design/lkvc_kv_mem.sv
// ----------------------------------------------------------------------------
// lkvc_kv_mem: key and value storage
// Two arrays sharing one write port and one registered read port. Contents
// are undefined until written; valid bits live in the recency cells.
// ----------------------------------------------------------------------------
module lkvc_kv_mem #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]      rd_addr_i,
  output logic [lkvc_pkg::KEY_W-1:0]          rd_key_o,
  output logic [lkvc_pkg::VALUE_W-1:0]        rd_value_o,
  input  logic                                we_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]      wr_addr_i,
  input  logic [lkvc_pkg::KEY_W-1:0]          wr_key_i,
  input  logic [lkvc_pkg::VALUE_W-1:0]        wr_value_i
);

  logic [lkvc_pkg::KEY_W-1:0]   key_mem   [MAX_ENTRIES];
  logic [lkvc_pkg::VALUE_W-1:0] value_mem [MAX_ENTRIES];
  logic [lkvc_pkg::KEY_W-1:0]   rd_key_q;
  logic [lkvc_pkg::VALUE_W-1:0] rd_value_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[wr_addr_i]   <= wr_key_i;
      value_mem[wr_addr_i] <= wr_value_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_key_q   <= key_mem[rd_addr_i];
    rd_value_q <= value_mem[rd_addr_i];
  end

  assign rd_key_o   = rd_key_q;
  assign rd_value_o = rd_value_q;

endmodule

### design/lkvc_recency.sv
// ----------------------------------------------------------------------------
// lkvc_recency: valid bits, recency ranks and entry count
// Rank 0 is the most recent entry; valid ranks are always 0 .. count-1.
// A touch ages every valid entry younger than the given age and zeroes the
// target slot; a fill does the same with age = count and claims the slot.
// ----------------------------------------------------------------------------
module lkvc_recency #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lkvc_pkg::rec_cmd_t                  cmd_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]      slot_i,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]    age_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]      rd_slot_i,
  output logic                                rd_valid_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]      rd_rank_o,
  output logic                                rd_oldest_o,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]    count_o
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [MAX_ENTRIES-1:0] valid_q;
  logic [IW-1:0]          rank_q [MAX_ENTRIES];
  logic [CW-1:0]          count_q;

  // Rank cells: each entry compares its own rank with the broadcast age
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.touch || cmd_i.fill) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot_i == IW'(i)) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && (CW'(rank_q[i]) < age_i)) begin
          rank_q[i] <= rank_q[i] + IW'(1);
        end
      end
      if (cmd_i.fill) begin
        valid_q[slot_i] <= 1'b1;
        count_q         <= count_q + CW'(1);
      end
    end
  end

  // Read at the scan position
  assign rd_valid_o  = valid_q[rd_slot_i];
  assign rd_rank_o   = rank_q[rd_slot_i];
  assign rd_oldest_o = valid_q[rd_slot_i] && ((CW'(rank_q[rd_slot_i]) + CW'(1)) == count_q);
  assign count_o     = count_q;

endmodule

### design/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value store, LRU replacement
// Lookup: the sequential key compare scans every entry, one per cycle through
//   the memory port; then the update state loads the result register, waiting
//   while it is stalled. One request at a time: in_stall_o is high until idle.
// Reset: valid bits, ranks and count clear at once; capacity resets to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration
  input  logic                                cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0]          cfg_wdata_i,
  // Request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic signed [lkvc_pkg::KEY_W-1:0]   key_i,
  input  logic signed [lkvc_pkg::VALUE_W-1:0] value_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic signed [lkvc_pkg::VALUE_W-1:0] read_value_o
);

  localparam int unsigned IW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

  lkvc_pkg::state_e state_q, state_d;

  logic [lkvc_pkg::CAP_W-1:0]   cap_q;
  logic                         kind_q;
  logic [lkvc_pkg::KEY_W-1:0]   key_q;
  logic [lkvc_pkg::VALUE_W-1:0] value_q;

  logic          issuing_q;
  logic [IW-1:0] addr_q;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;

  logic                         hit_found_q;
  logic [IW-1:0]                hit_idx_q;
  logic [IW-1:0]                hit_rank_q;
  logic [lkvc_pkg::VALUE_W-1:0] hit_val_q;
  logic                         free_found_q;
  logic [IW-1:0]                free_idx_q;
  logic [IW-1:0]                vict_idx_q;

  logic                         out_valid_q;
  logic                         out_hit_q;
  logic [lkvc_pkg::VALUE_W-1:0] out_value_q;

  logic                         accept;
  logic                         out_free;
  logic                         scan_last;
  logic                         out_load;
  logic                         mem_we;
  logic [IW-1:0]                mem_wr_addr;
  logic [lkvc_pkg::KEY_W-1:0]   rd_key;
  logic [lkvc_pkg::VALUE_W-1:0] rd_value;
  lkvc_pkg::rec_cmd_t           rec_cmd;
  logic [IW-1:0]                rec_slot;
  logic [CW-1:0]                rec_age;
  logic                         rd_valid;
  logic [IW-1:0]                rd_rank;
  logic                         rd_oldest;
  logic [CW-1:0]                count;
  logic [CMPW-1:0]              cap_ext;
  logic [CMPW-1:0]              eff_cap;
  logic                         full;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != lkvc_pkg::ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_last = cmp_vld_q && (cmp_idx_q == IW'(MAX_ENTRIES - 1));

  // Effective capacity: zero acts as one, clamp at the store size
  assign cap_ext = CMPW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
      eff_cap = CMPW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = (CMPW'(count) >= eff_cap);

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, update commands and write-back
  always_comb begin
    state_d     = state_q;
    rec_cmd     = '0;
    rec_slot    = '0;
    rec_age     = '0;
    mem_we      = 1'b0;
    mem_wr_addr = '0;
    out_load    = 1'b0;
    case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lkvc_pkg::ST_SCAN;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = lkvc_pkg::ST_UPDATE;
        end
      end
      lkvc_pkg::ST_UPDATE: begin
        if (kind_q == lkvc_pkg::KIND_LOOKUP) begin
          // hold here until the result register can take the result
          if (out_free) begin
            out_load      = 1'b1;
            rec_cmd.touch = hit_found_q;
            rec_slot      = hit_idx_q;
            rec_age       = CW'(hit_rank_q);
            state_d       = lkvc_pkg::ST_IDLE;
          end
        end else begin
          mem_we = 1'b1;
          if (hit_found_q) begin
            // update in place
            rec_cmd.touch = 1'b1;
            rec_slot      = hit_idx_q;
            rec_age       = CW'(hit_rank_q);
            mem_wr_addr   = hit_idx_q;
          end else if (full) begin
            // replace the least recent entry
            rec_cmd.touch = 1'b1;
            rec_slot      = vict_idx_q;
            rec_age       = count - CW'(1);
            mem_wr_addr   = vict_idx_q;
          end else begin
            // claim the lowest free slot
            rec_cmd.fill = 1'b1;
            rec_slot     = free_idx_q;
            rec_age      = count;
            mem_wr_addr  = free_idx_q;
          end
          state_d = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // Scan address generator and compare unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q    <= 1'b0;
      addr_q       <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else if (accept) begin
      issuing_q    <= 1'b1;
      addr_q       <= '0;
      cmp_vld_q    <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      cmp_vld_q <= issuing_q;
      cmp_idx_q <= addr_q;
      if (issuing_q) begin
        if (addr_q == IW'(MAX_ENTRIES - 1)) begin
          issuing_q <= 1'b0;
        end else begin
          addr_q <= addr_q + IW'(1);
        end
      end
      if (cmp_vld_q) begin
        if (rd_valid && (rd_key == key_q)) begin
          hit_found_q <= 1'b1;
        end
        if (!rd_valid && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
    end
  end

  // Scan results: slot numbers, rank and value of the matches
  always_ff @(posedge clk_i) begin
    if (cmp_vld_q) begin
      if (rd_valid && (rd_key == key_q)) begin
        hit_idx_q  <= cmp_idx_q;
        hit_rank_q <= rd_rank;
        hit_val_q  <= rd_value;
      end
      if (!rd_valid && !free_found_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (rd_oldest) begin
        vict_idx_q <= cmp_idx_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hit_q   <= hit_found_q;
      out_value_q <= hit_found_q ? hit_val_q : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign read_value_o = out_value_q;

  // Key/value storage
  lkvc_kv_mem #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_kv_mem (
    .clk_i     (clk_i),
    .rd_addr_i (addr_q),
    .rd_key_o  (rd_key),
    .rd_value_o(rd_value),
    .we_i      (mem_we),
    .wr_addr_i (mem_wr_addr),
    .wr_key_i  (key_q),
    .wr_value_i(value_q)
  );

  // Valid bits, ranks and count
  lkvc_recency #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_recency (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (rec_cmd),
    .slot_i     (rec_slot),
    .age_i      (rec_age),
    .rd_slot_i  (cmp_idx_q),
    .rd_valid_o (rd_valid),
    .rd_rank_o  (rd_rank),
    .rd_oldest_o(rd_oldest),
    .count_o    (count)
  );

endmodule
